>>> rtl/ed23_pkg.sv
// Shared types, constants and the Scale2x expansion function for the upscaler.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
package ed23_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_STRIP_ROWS = 1024;
    localparam int MAX_STRIPS     = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SROW_W  = $clog2(MAX_STRIP_ROWS);
    localparam int STRIP_W = $clog2(MAX_STRIPS);
    localparam int ROW_W   = SROW_W + STRIP_W;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 24;

    localparam int LINE_DEPTH = 3 * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int JOB_SLOTS  = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCALE_MODE   = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_STRIP_HEIGHT = 2'd2;
    localparam logic [1:0] REG_STRIP_COUNT  = 2'd3;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic              scale3;
        logic [COL_W-1:0]  w_m1;
        logic [SROW_W-1:0] sh_m1;
        logic [STRIP_W-1:0] cnt_m1;
    } geom_t;

    typedef struct packed {
        logic [COL_W-1:0]   cx;
        logic [COORD_W-1:0] cy;
        pixel_t [3:0]       e;
    } center_t;

    typedef struct packed {
        logic [2:0]                count;
        center_t [JOB_SLOTS-1:0]   ctr;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD2,
        F_HAND
    } fetch_state_t;

    function automatic logic [ADDR_W-1:0] line_addr(input logic [1:0] slot,
                                                    input logic [COL_W-1:0] col);
        line_addr = ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    // Scale2x rules; element 0 is e0 (upper left).
    function automatic pixel_t [3:0] scale2x(input pixel_t b, input pixel_t d,
                                             input pixel_t e, input pixel_t f,
                                             input pixel_t h);
        logic db, bf, dh, hf;
        pixel_t [3:0] r;
        db = (d == b);
        bf = (b == f);
        dh = (d == h);
        hf = (h == f);
        r[0] = (db && !bf && !dh) ? d : e;
        r[1] = (bf && !db && !hf) ? f : e;
        r[2] = (dh && !db && !hf) ? d : e;
        r[3] = (hf && !dh && !bf) ? f : e;
        scale2x = r;
    endfunction

endpackage

>>> rtl/ed23_line_ram.sv
// Line store: three source rows in one simple dual-port RAM.
// One write and one registered read per cycle. Uses ed23_pkg.
`timescale 1ns / 1ps
module ed23_line_ram
    import ed23_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pixel_t            rd_data
);

    pixel_t mem [0:LINE_DEPTH-1];
    pixel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ed23_window.sv
// Input side: raster counters, line store accesses, 3x3 column window and
// construction of the centers each source pixel completes. Uses ed23_pkg.
`timescale 1ns / 1ps
module ed23_window
    import ed23_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  geom_t             geom,
    input  logic              restart,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pixel_t            s_pix,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output pixel_t            wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  pixel_t            rd_data,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    fetch_state_t state_reg, state_next;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SROW_W-1:0]  srow_reg;
    logic [STRIP_W-1:0] strip_reg;
    logic [1:0]         slot_reg;

    pixel_t             it_pix_reg;
    logic [COL_W-1:0]   it_x_reg;
    logic [ROW_W-1:0]   it_y_reg;
    logic [1:0]         it_s2_reg;
    logic it_a_reg, it_b_reg, it_lastc_reg, it_y0_reg, it_y1_reg, it_x0_reg, it_x1_reg;

    pixel_t  mid_reg;
    column_t p1_reg, p2_reg;

    logic       accept, hand;
    logic [1:0] s1, s2;
    column_t    cn;
    center_t [JOB_SLOTS-1:0] cand;
    logic    [JOB_SLOTS-1:0] cv;
    logic [COORD_W-1:0] cya, cyb;
    logic [COL_W-1:0]   cxm1;

    assign accept = s_tvalid && s_tready;
    assign hand   = (state_reg == F_HAND) && job_ready;
    assign s1 = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign s2 = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_RD2;
            F_RD2:  state_next = F_HAND;
            F_HAND: if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == F_IDLE);
        job_valid = (state_reg == F_HAND);
        wr_en     = accept;
        wr_addr   = line_addr(slot_reg, col_reg);
        wr_data   = s_pix;
        rd_en     = accept || (state_reg == F_RD2);
        rd_addr   = (state_reg == F_RD2) ? line_addr(it_s2_reg, it_x_reg)
                                         : line_addr(s1, col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            srow_reg  <= '0;
            strip_reg <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (restart) begin
                col_reg   <= '0;
                row_reg   <= '0;
                srow_reg  <= '0;
                strip_reg <= '0;
                slot_reg  <= '0;
            end else if (accept) begin
                if (col_reg == geom.w_m1) begin
                    col_reg <= '0;
                    if (srow_reg == geom.sh_m1 && strip_reg == geom.cnt_m1) begin
                        row_reg   <= '0;
                        srow_reg  <= '0;
                        strip_reg <= '0;
                        slot_reg  <= '0;
                    end else begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= s2;
                        if (srow_reg == geom.sh_m1) begin
                            srow_reg  <= '0;
                            strip_reg <= strip_reg + 1'b1;
                        end else begin
                            srow_reg <= srow_reg + 1'b1;
                        end
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            it_pix_reg   <= s_pix;
            it_x_reg     <= col_reg;
            it_y_reg     <= row_reg;
            it_s2_reg    <= s2;
            it_a_reg     <= (row_reg != '0) && (srow_reg != '0);
            it_b_reg     <= (srow_reg == geom.sh_m1);
            it_lastc_reg <= (col_reg == geom.w_m1);
            it_y0_reg    <= (row_reg == '0);
            it_y1_reg    <= (row_reg == ROW_W'(1));
            it_x0_reg    <= (col_reg == '0);
            it_x1_reg    <= (col_reg == COL_W'(1));
        end
        if (state_reg == F_RD2) begin
            mid_reg <= rd_data;
        end
        if (hand) begin
            p2_reg <= p1_reg;
            p1_reg <= cn;
        end
    end

    // Newest column: two rows above come from the store, this row from the input.
    assign cn   = '{top: rd_data, mid: mid_reg, bot: it_pix_reg};
    assign cya  = COORD_W'(it_y_reg - 1'b1);
    assign cyb  = COORD_W'(it_y_reg);
    assign cxm1 = it_x_reg - 1'b1;

    always_comb begin
        logic [2:0] n;
        // Centers of the previous row, left one first.
        cv[0] = it_a_reg && !it_x0_reg;
        cand[0].cx = cxm1;
        cand[0].cy = cya;
        cand[0].e  = scale2x(it_y1_reg ? p1_reg.mid : p1_reg.top,
                             it_x1_reg ? p1_reg.mid : p2_reg.mid,
                             p1_reg.mid, cn.mid, p1_reg.bot);
        cv[1] = it_a_reg && it_lastc_reg;
        cand[1].cx = it_x_reg;
        cand[1].cy = cya;
        cand[1].e  = scale2x(it_y1_reg ? cn.mid : cn.top,
                             it_x0_reg ? cn.mid : p1_reg.mid,
                             cn.mid, cn.mid, cn.bot);
        // Centers of the current row at a strip's last row; below clamps to E.
        cv[2] = it_b_reg && !it_x0_reg;
        cand[2].cx = cxm1;
        cand[2].cy = cyb;
        cand[2].e  = scale2x(it_y0_reg ? p1_reg.bot : p1_reg.mid,
                             it_x1_reg ? p1_reg.bot : p2_reg.bot,
                             p1_reg.bot, cn.bot, p1_reg.bot);
        cv[3] = it_b_reg && it_lastc_reg;
        cand[3].cx = it_x_reg;
        cand[3].cy = cyb;
        cand[3].e  = scale2x(it_y0_reg ? cn.bot : cn.mid,
                             it_x0_reg ? cn.bot : p1_reg.bot,
                             cn.bot, cn.bot, cn.bot);

        job.ctr = cand;
        n = 3'd0;
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (cv[i]) begin
                job.ctr[n[1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
        job.count = n;
    end

endmodule

>>> rtl/ed23_emit.sv
// Output side: holds one job of up to four centers and sends their output
// pixels one per transfer through a registered output stage. Uses ed23_pkg.
`timescale 1ns / 1ps
module ed23_emit
    import ed23_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                scale3,
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [COORD_W-1:0]  m_x,
    output logic [COORD_W-1:0]  m_y,
    output pixel_t              m_pix,
    output logic                m_tlast
);

    center_t [JOB_SLOTS-1:0] ctr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] ci_reg, sc_reg, sr_reg;
    logic       m_tvalid_reg;

    logic [COORD_W-1:0] x_reg, y_reg;
    pixel_t             pix_reg;
    logic               last_reg;

    logic       fire, sub_end, ci_last, load;
    logic [1:0] smax;
    center_t    cur;
    logic [COORD_W-1:0] bx, by;

    assign smax    = scale3 ? 2'd2 : 2'd1;
    assign cur     = ctr_reg[ci_reg];
    assign fire    = (cnt_reg != 3'd0) && (!m_tvalid_reg || m_tready);
    assign sub_end = (sc_reg == smax) && (sr_reg == smax);
    assign ci_last = ({1'b0, ci_reg} == cnt_reg - 3'd1);
    assign job_ready = (cnt_reg == 3'd0) || (fire && sub_end && ci_last);
    assign load    = job_valid && job_ready;

    assign bx = COORD_W'({cur.cx, 1'b0}) + (scale3 ? COORD_W'(cur.cx) : '0);
    assign by = COORD_W'({cur.cy, 1'b0}) + (scale3 ? cur.cy : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            ci_reg       <= '0;
            sc_reg       <= '0;
            sr_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fire) begin
                if (sub_end) begin
                    sc_reg <= '0;
                    sr_reg <= '0;
                    if (ci_last) begin
                        cnt_reg <= '0;
                    end else begin
                        ci_reg <= ci_reg + 2'd1;
                    end
                end else if (sc_reg == smax) begin
                    sc_reg <= '0;
                    sr_reg <= sr_reg + 2'd1;
                end else begin
                    sc_reg <= sc_reg + 2'd1;
                end
            end
            if (load) begin
                cnt_reg <= job.count;
                ci_reg  <= '0;
                sc_reg  <= '0;
                sr_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctr_reg <= job.ctr;
        end
        if (fire) begin
            x_reg    <= bx + COORD_W'(sc_reg);
            y_reg    <= by + COORD_W'(sr_reg);
            // Lower half for the last sub-row, right half for any column but the first.
            pix_reg  <= cur.e[{sr_reg == smax, sc_reg != 2'd0}];
            last_reg <= sub_end && ci_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_x      = x_reg;
    assign m_y      = y_reg;
    assign m_pix    = pix_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/edge_directed_2x_3x_upscaler.sv
// Top level of the edge-directed 2x / 3x pixel-art upscaler.
// Holds the configuration registers and joins window, line RAM and emitter.
// Depends on ed23_pkg, ed23_line_ram, ed23_window and ed23_emit.
//
// Usage:
//   Source pixels enter in raster order on the s_ stream, one per transfer.
//   Each completed center pixel leaves on the m_ stream as 4 pixels (2x) or
//   9 pixels (3x), each with its destination coordinates; m_tlast marks the
//   final pixel caused by one source pixel. Input pixels that complete no
//   center produce no transfer at all.
//   Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data
//   while the block is idle. cfg_ready is always high. Writing the width,
//   strip height or strip count restarts the frame; writing the mode does not.
// Flow:
//   A source pixel is taken only while the window is idle: the line RAM
//   read port fetches the row above as the pixel is taken and the row two
//   above in the read state F_RD2, and a hand-off state then passes the
//   finished centers to the emitter once it is free. The window can take the
//   next source pixel while the emitter still sends earlier centers. The emitter
//   sends one output pixel per cycle while it holds centers and m_tready is high.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the counters and handshake state
//   and loads the register defaults; the line RAM is not cleared. When the
//   receiver holds m_tready low the output register holds its transfer; the
//   next source pixel is still fetched and waits with its centers until the
//   emitter frees its job slot.
`timescale 1ns / 1ps
module edge_directed_2x_3x_upscaler
    import ed23_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Source pixel stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Output pixel stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // dest_x[11:0], dest_y[23:12], out_red[31:24],
                                   // out_green[39:32], out_blue[47:40]
    output logic        m_tlast,   // last pixel caused by one source transfer
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    logic             mode_reg;
    logic [CFG_W-1:0] width_reg, height_reg, count_reg;

    logic   cfg_fire, restart;
    geom_t  geom;
    logic   job_valid, job_ready;
    job_t   job;
    logic   wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    pixel_t wr_data, rd_data, m_pix;
    logic [COORD_W-1:0] m_x, m_y;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index != REG_SCALE_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            width_reg  <= CFG_W'(320);
            height_reg <= CFG_W'(200);
            count_reg  <= CFG_W'(1);
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_SCALE_MODE:   mode_reg   <= cfg_data[0];
                REG_LINE_WIDTH:   width_reg  <= cfg_data;
                REG_STRIP_HEIGHT: height_reg <= cfg_data;
                REG_STRIP_COUNT:  count_reg  <= cfg_data;
                default:          mode_reg   <= mode_reg;
            endcase
        end
    end

    // Geometry is clamped into its legal range and kept as "value minus one".
    always_comb begin
        geom.scale3 = mode_reg;
        if (width_reg == '0)
            geom.w_m1 = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            geom.w_m1 = COL_W'(MAX_WIDTH - 1);
        else
            geom.w_m1 = COL_W'(width_reg - 1'b1);
        if (height_reg == '0)
            geom.sh_m1 = '0;
        else if (32'(height_reg) > MAX_STRIP_ROWS)
            geom.sh_m1 = SROW_W'(MAX_STRIP_ROWS - 1);
        else
            geom.sh_m1 = SROW_W'(height_reg - 1'b1);
        if (count_reg == '0)
            geom.cnt_m1 = '0;
        else if (32'(count_reg) > MAX_STRIPS)
            geom.cnt_m1 = STRIP_W'(MAX_STRIPS - 1);
        else
            geom.cnt_m1 = STRIP_W'(count_reg - 1'b1);
    end

    ed23_line_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ed23_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .restart   (restart),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pix     ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ed23_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scale3    (mode_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_x       (m_x),
        .m_y       (m_y),
        .m_pix     (m_pix),
        .m_tlast   (m_tlast)
    );

    // Internal pixels are red in the high byte.
    assign m_tdata = {m_pix[7:0], m_pix[15:8], m_pix[23:16], m_y, m_x};

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the edge-directed 2x / 3x pixel-art upscaler.
// Drives source pixels and register writes, predicts every output pixel and
// compares them in order. Depends on ed23_pkg and edge_directed_2x_3x_upscaler.
`timescale 1ns / 1ps
module tb_top;
    import ed23_pkg::*;

    // One expected output pixel, with its destination and the tlast flag.
    typedef struct {
        logic [11:0] dx;
        logic [11:0] dy;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } out_pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SCALE_MODE;
    logic [10:0] cfg_data = '0;

    // Source pixels waiting to be sent, and output pixels still owed.
    logic [23:0] pixel_fifo[$];
    out_pixel_t  owed_pixels[$];

    int error_count = 0;
    int src_idle_pct = 0;   // chance per cycle that the sender idles
    int sink_stall_pct = 0; // chance per cycle that the receiver stalls
    bit hold_source = 1'b0; // sender pauses while set

    // Shadow of the block: registers, counters and the three-row line store.
    logic [23:0] row_store[0:LINE_DEPTH-1];
    int          mode_reg = 0;
    int          width_reg = 320;
    int          height_reg = 200;
    int          strips_reg = 1;
    int          col_pos = 0;
    int          row_pos = 0;
    int          strip_row = 0;

    // Colors used to build content with many equal neighbors.
    logic [23:0] palette[3];

    edge_directed_2x_3x_upscaler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int clamp_geom(input int v);
        if (v < 1) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic logic [23:0] store_at(input int slot, input int col);
        return row_store[slot * MAX_WIDTH + col];
    endfunction

    // Expands one center with the Scale2x rules and appends its output pixels.
    task automatic expand_center(input int cx, input int cy, input int su,
                                 input int sc, input int sd, input int w);
        int          xl;
        int          xr;
        int          x0;
        int          y0;
        int          k;
        int          scale;
        logic [23:0] b, d, e, f, h;
        logic [23:0] quad[4];
        logic [23:0] color;
        int          sub_x;
        int          sub_y;
        int          sel;
        out_pixel_t  op;
        xl = (cx == 0) ? 0 : cx - 1;
        xr = (cx + 1 >= w) ? cx : cx + 1;
        b = store_at(su, cx);
        d = store_at(sc, xl);
        e = store_at(sc, cx);
        f = store_at(sc, xr);
        h = store_at(sd, cx);
        quad[0] = (d == b && b != f && d != h) ? d : e;
        quad[1] = (b == f && b != d && f != h) ? f : e;
        quad[2] = (d == h && d != b && h != f) ? d : e;
        quad[3] = (h == f && d != h && b != f) ? f : e;
        scale = mode_reg[0] ? 3 : 2;
        x0 = cx * scale;
        y0 = cy * scale;
        for (k = 0; k < scale * scale; k++) begin
            sub_x = k % scale;
            sub_y = k / scale;
            // In 3x mode the middle row repeats the top row, and the right
            // column repeats the middle column.
            sel = ((sub_y == scale - 1 && scale == 3) || (scale == 2 && sub_y == 1)) ? 2 : 0;
            sel += (sub_x > 0) ? 1 : 0;
            color = quad[sel];
            op.dx = 12'(x0 + sub_x);
            op.dy = 12'(y0 + sub_y);
            op.red = color[23:16];
            op.green = color[15:8];
            op.blue = color[7:0];
            op.last = 1'b0;
            owed_pixels.push_back(op);
        end
    endtask

    // Stores one accepted source pixel and predicts the centers it completes.
    task automatic upscale_pixel(input logic [23:0] px);
        int         w;
        int         sh;
        int         rows;
        int         x;
        int         y;
        int         s0, s1, s2;
        int         su;
        int         base;
        out_pixel_t op;
        w = clamp_geom(width_reg);
        sh = clamp_geom(height_reg);
        rows = sh * clamp_geom(strips_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = row_pos;
        s0 = y % 3;
        s1 = (y + 2) % 3;
        s2 = (y + 1) % 3;
        base = owed_pixels.size();
        // The store keeps pixels as red in the top byte, blue in the bottom.
        row_store[s0 * MAX_WIDTH + x] = {px[7:0], px[15:8], px[23:16]};
        if (y >= 1 && strip_row != 0) begin
            su = (y == 1) ? s1 : s2;
            if (x >= 1) expand_center(x - 1, y - 1, su, s1, s0, w);
            if (x == w - 1) expand_center(x, y - 1, su, s1, s0, w);
        end
        if (strip_row >= sh - 1) begin
            su = (y == 0) ? s0 : s1;
            if (x >= 1) expand_center(x - 1, y, su, s0, s0, w);
            if (x == w - 1) expand_center(x, y, su, s0, s0, w);
        end
        if (owed_pixels.size() > base) begin
            op = owed_pixels.pop_back();
            op.last = 1'b1;
            owed_pixels.push_back(op);
        end
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            strip_row++;
            if (strip_row >= sh) strip_row = 0;
            if (row_pos >= rows) begin
                row_pos = 0;
                strip_row = 0;
            end
        end else begin
            col_pos = x + 1;
        end
    endtask

    // Register writes update the shadow copy on the transfer edge.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCALE_MODE: begin
                    mode_reg = cfg_data[0];
                end
                REG_LINE_WIDTH: begin
                    width_reg = cfg_data;
                    col_pos = 0; row_pos = 0; strip_row = 0;
                end
                REG_STRIP_HEIGHT: begin
                    height_reg = cfg_data;
                    col_pos = 0; row_pos = 0; strip_row = 0;
                end
                default: begin
                    strips_reg = cfg_data;
                    col_pos = 0; row_pos = 0; strip_row = 0;
                end
            endcase
        end
    end

    // Source driver: predicts on each accepted transfer, then offers the next
    // pixel unless it idles this cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) upscale_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_fifo.size() > 0 && !hold_source &&
                    $urandom_range(99) >= src_idle_pct) begin
                    s_tdata <= pixel_fifo.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random back-pressure and an in-order compare.
    always @(posedge aclk) begin
        out_pixel_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (owed_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected output pixel %h", m_tdata));
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_tdata[11:0] !== want.dx || m_tdata[23:12] !== want.dy ||
                        m_tdata[31:24] !== want.red || m_tdata[39:32] !== want.green ||
                        m_tdata[47:40] !== want.blue || m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "got x%0d y%0d rgb %h%h%h last %b, want x%0d y%0d rgb %h%h%h last %b",
                            m_tdata[11:0], m_tdata[23:12], m_tdata[31:24], m_tdata[39:32],
                            m_tdata[47:40], m_tlast, want.dx, want.dy, want.red,
                            want.green, want.blue, want.last));
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Waits until every pixel is sent and every output has arrived, then lets
    // the pipeline settle so an item that completes no center is finished.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pixel_fifo.size() != 0 || s_tvalid || owed_pixels.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= 11'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int mode, input int w, input int h, input int n);
        wait_idle();
        write_reg(REG_SCALE_MODE, mode);
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_STRIP_HEIGHT, h);
        write_reg(REG_STRIP_COUNT, n);
    endtask

    // Idle pattern for a group of settings: none, sender, receiver, both.
    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin src_idle_pct = 0; sink_stall_pct = 0; end
            1: begin src_idle_pct = 51; sink_stall_pct = 0; end
            2: begin src_idle_pct = 0; sink_stall_pct = 51; end
            default: begin src_idle_pct = 23; sink_stall_pct = 23; end
        endcase
    endtask

    function automatic int pick_size();
        case ($urandom_range(19))
            0: return 0;      // clamps up to one
            1: return 2047;   // clamps down to the maximum
            2: return 1024;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    initial begin
        int          k;
        int          setting;
        int          w;
        int          h;
        int          n;
        int          frame_px;
        int          burst;
        bit          noisy;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: a 3x4 frame in two strips of two rows, built from
        // black, white and one mid color so every rule fires, including the
        // clamped left and right columns and the strip boundary.
        set_geometry(0, 3, 2, 2);
        pixel_fifo = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                       24'h000000, 24'h5A3CC3, 24'hFFFFFF,
                       24'h5A3CC3, 24'h000000, 24'h000000,
                       24'hFFFFFF, 24'h000000, 24'h5A3CC3};
        // Three pixels in 3x mode, in a one-column, one-row-strip frame.
        set_geometry(1, 1, 1, 1);
        pixel_fifo = '{24'hFFFFFF, 24'h000000, 24'hA5C33C};
        // Two-column frame in 3x mode, then a mode-only write mid-frame.
        set_geometry(1, 2, 3, 1);
        pixel_fifo = '{24'h010203, 24'h010203, 24'hFFFFFF, 24'h010203};
        wait_idle();
        write_reg(REG_SCALE_MODE, 0);
        pixel_fifo = '{24'h010203, 24'hFFFFFF};

        // Random part: many small geometries with palette content, and some
        // fully random pixels so every data bit toggles.
        for (setting = 0; setting < 28; setting++) begin
            w = pick_size();
            h = pick_size();
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
            set_geometry($urandom_range(1), w, h, n);
            set_idling(setting / 3);
            for (k = 0; k < 3; k++) palette[k] = 24'($urandom);
            noisy = ($urandom_range(4) == 0);
            frame_px = clamp_geom(w) * clamp_geom(h) * clamp_geom(n);
            burst = $urandom_range(8, 30);
            if (burst > 2 * frame_px && frame_px > 0) burst = 2 * frame_px + 1;
            for (k = 0; k < burst; k++)
                pixel_fifo.push_back(noisy ? 24'($urandom) : palette[$urandom_range(2)]);
            if (setting == 13) begin
                // Let part of the burst go, then hold the sender until every
                // owed output has come back before the rest is released.
                repeat (20) @(posedge aclk);
                hold_source = 1'b1;
                do @(posedge aclk);
                while (s_tvalid || owed_pixels.size() != 0);
                hold_source = 1'b0;
            end
        end

        // Tall frame of one-row strips in 3x mode under mixed idling.
        set_geometry(1, 1, 1, 1024);
        set_idling(3);
        for (k = 0; k < 40; k++) pixel_fifo.push_back(palette[$urandom_range(1)]);

        wait_idle();
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog far above the slowest legal run.
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
